@@ sv/msp_pkg.sv @@
`timescale 1ns / 1ps

package msp_pkg;

    // Timing constants, all in ms
    localparam logic [15:0] BLANK_WINDOW    = 16'd120;
    localparam logic [15:0] CONFIRM_WINDOW  = 16'd80;
    localparam logic [15:0] BACKOFF_WINDOW  = 16'd120;
    localparam logic [15:0] COOLDOWN_WINDOW = 16'd200;
    localparam logic [15:0] RETRY_CLEAR_MS  = 16'd1000;

    localparam logic [7:0]  MAX_RETRIES  = 8'd2;
    localparam logic [7:0]  RETRY_MAX    = 8'd255;
    localparam logic [2:0]  VOTES_NEEDED = 3'd3;

    // Angles in centidegrees
    localparam logic signed [17:0] MARGIN_CDEG  = 18'sd200;
    localparam logic signed [17:0] BACKOFF_CDEG = 18'sd400;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_BACKOFF  = 2'd1,
        MODE_COOLDOWN = 2'd2,
        MODE_FAULT    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE        = 3'd0,
        CFG_MAX_ANGLE        = 3'd1,
        CFG_CMD_DIR_POSITIVE = 3'd2,
        CFG_CMD_THRESHOLD    = 3'd3,
        CFG_TORQUE_THRESHOLD = 3'd4,
        CFG_SPEED_THRESHOLD  = 3'd5,
        CFG_ERROR_THRESHOLD  = 3'd6,
        CFG_BACKOFF_LIMIT    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] min_angle;
        logic signed [15:0] max_angle;
        logic               cmd_dir_positive;
        logic [14:0]        cmd_threshold;
        logic [14:0]        torque_threshold;
        logic [14:0]        speed_threshold;
        logic [15:0]        error_threshold;
        logic [14:0]        backoff_limit;
    } msp_cfg_t;

    typedef struct packed {
        logic signed [15:0] target_angle;
        logic signed [15:0] feedback_angle;
        logic signed [15:0] speed;
        logic signed [15:0] raw_cmd;
        logic signed [15:0] torque_fb;
        logic [15:0]        elapsed_ms;
        logic               active;
        logic               clear_fault;
        logic               blank_timers;
    } msp_in_t;

    typedef struct packed {
        logic signed [15:0] out_cmd;
        logic signed [15:0] out_target;
        logic [1:0]         protect_state;
        logic               fault;
        logic               loop_reset;
        logic signed [15:0] reset_target;
    } msp_out_t;

endpackage

@@ sv/msp_if.sv @@
`timescale 1ns / 1ps

interface msp_in_if import msp_pkg::*; ();
    logic    valid;
    logic    ready;
    msp_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface msp_out_if import msp_pkg::*; ();
    logic     valid;
    logic     ready;
    msp_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/motor_stall_protection_unit.sv @@
`timescale 1ns / 1ps

// Stall protection for one position-controlled axis. Each input word is one
// control tick and gives exactly one result word, in order. A word is taken
// into an input register, and when it moves on, its whole update (stall
// vote, timers, mode change, protected command) is worked out in one pass and
// written to the result register together with the protection state. Both
// registers move together, so one word is accepted every clock cycle while
// the result channel is not stalled; a word goes through the input register
// and then the result register before it is presented on the result channel.
// The rate is set by the one-pass state update in msp_step. The input side
// keeps accepting while a result waits, until both stages are full.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no word is in flight.

module motor_stall_protection_unit import msp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    msp_in_if.sink                ctl,
    msp_out_if.source             res
);

    msp_cfg_t cfg;

    // Input stage
    logic     in_valid_reg;
    logic     in_valid_next;
    msp_in_t  in_data_reg;

    // Result stage
    logic     out_valid_reg;
    logic     out_valid_next;
    msp_out_t out_data_reg;
    msp_out_t step_result;

    logic     advance;
    logic     take;

    msp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The step unit owns the protection state; it commits only when the
    // word in the input register moves into the result register.
    msp_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Move forward when the result slot is free or is being emptied now
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign ctl.ready = !in_valid_reg || advance;
    assign take      = ctl.valid && ctl.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= ctl.data;
        if (advance)
            out_data_reg <= step_result;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

endmodule

@@ sv/msp_cfg.sv @@
`timescale 1ns / 1ps

module msp_cfg import msp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output msp_cfg_t              cfg
);

    msp_cfg_t cfg_reg;
    msp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_ANGLE:        cfg_next.min_angle        = $signed(cfg_data);
                CFG_MAX_ANGLE:        cfg_next.max_angle        = $signed(cfg_data);
                CFG_CMD_DIR_POSITIVE: cfg_next.cmd_dir_positive = cfg_data[0];
                CFG_CMD_THRESHOLD:    cfg_next.cmd_threshold    = cfg_data[14:0];
                CFG_TORQUE_THRESHOLD: cfg_next.torque_threshold = cfg_data[14:0];
                CFG_SPEED_THRESHOLD:  cfg_next.speed_threshold  = cfg_data[14:0];
                CFG_ERROR_THRESHOLD:  cfg_next.error_threshold  = cfg_data;
                CFG_BACKOFF_LIMIT:    cfg_next.backoff_limit    = cfg_data[14:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_angle        <= -16'sd3000;
            cfg_reg.max_angle        <= 16'sd3000;
            cfg_reg.cmd_dir_positive <= 1'b1;
            cfg_reg.cmd_threshold    <= 15'd3500;
            cfg_reg.torque_threshold <= 15'd700;
            cfg_reg.speed_threshold  <= 15'd150;
            cfg_reg.error_threshold  <= 16'd250;
            cfg_reg.backoff_limit    <= 15'd2500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/msp_step.sv @@
`timescale 1ns / 1ps

module msp_step import msp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  msp_in_t  item,
    input  msp_cfg_t cfg,
    output msp_out_t result
);

    mode_t              mode_reg, mode_next;
    logic [15:0]        state_timer_reg, state_timer_next;
    logic [15:0]        stall_timer_reg, stall_timer_next;
    logic [7:0]         retry_reg, retry_next;
    logic signed [15:0] btgt_reg, btgt_next;
    logic               active_prev_reg, active_prev_next;
    logic               req;

    logic [15:0]        dt;
    logic signed [15:0] lo, hi;
    logic signed [17:0] fb18, lo18, hi18, bt_raw;
    logic               near_hi, near_lo, outward;
    logic signed [16:0] err;
    logic [16:0]        abs_cmd, abs_trq, abs_spd, abs_err;
    logic [2:0]         votes;
    logic signed [15:0] bt_clamped;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [16:0] mag17(input logic signed [16:0] x);
        return x[16] ? 17'(-x) : 17'(x);
    endfunction

    // Per-word terms that do not depend on state
    assign dt   = (item.elapsed_ms == 16'd0) ? 16'd1 : item.elapsed_ms;
    assign lo   = (cfg.min_angle > cfg.max_angle) ? cfg.max_angle : cfg.min_angle;
    assign hi   = (cfg.min_angle > cfg.max_angle) ? cfg.min_angle : cfg.max_angle;
    assign fb18 = 18'(item.feedback_angle);
    assign lo18 = 18'(lo);
    assign hi18 = 18'(hi);

    assign near_hi = fb18 >= (hi18 - MARGIN_CDEG);
    assign near_lo = fb18 <= (lo18 + MARGIN_CDEG);

    always_comb
    begin
        outward = 1'b0;
        if (near_hi)
            outward = cfg.cmd_dir_positive ? (item.raw_cmd > 16'sd0) : (item.raw_cmd < 16'sd0);
        else if (near_lo)
            outward = cfg.cmd_dir_positive ? (item.raw_cmd < 16'sd0) : (item.raw_cmd > 16'sd0);
    end

    assign err     = 17'(item.target_angle) - 17'(item.feedback_angle);
    assign abs_cmd = mag17(17'(item.raw_cmd));
    assign abs_trq = mag17(17'(item.torque_fb));
    assign abs_spd = mag17(17'(item.speed));
    assign abs_err = mag17(err);

    assign votes = 3'(abs_cmd > {2'b00, cfg.cmd_threshold})
                 + 3'(abs_trq > {2'b00, cfg.torque_threshold})
                 + 3'(abs_spd < {2'b00, cfg.speed_threshold})
                 + 3'(abs_err > {1'b0, cfg.error_threshold});

    // Retreat target, 4 degrees away from the limit being hit, kept inside the range
    always_comb
    begin
        bt_raw = near_hi ? (fb18 - BACKOFF_CDEG) : (fb18 + BACKOFF_CDEG);
        if (bt_raw < lo18)
            bt_clamped = lo;
        else if (bt_raw > hi18)
            bt_clamped = hi;
        else
            bt_clamped = bt_raw[15:0];
    end

    // Next state
    always_comb
    begin
        mode_next        = mode_reg;
        state_timer_next = state_timer_reg;
        stall_timer_next = stall_timer_reg;
        retry_next       = retry_reg;
        btgt_next        = btgt_reg;
        active_prev_next = active_prev_reg;
        req              = 1'b0;

        if (item.active != active_prev_reg)
        begin
            active_prev_next = item.active;
            state_timer_next = '0;
            stall_timer_next = '0;
            if (!item.active)
            begin
                mode_next  = MODE_NORMAL;
                retry_next = '0;
                btgt_next  = '0;
            end
        end
        if (item.clear_fault)
        begin
            mode_next        = MODE_NORMAL;
            state_timer_next = '0;
            stall_timer_next = '0;
            retry_next       = '0;
        end
        if (item.blank_timers)
        begin
            state_timer_next = '0;
            stall_timer_next = '0;
        end

        if (item.active)
        begin
            case (mode_next)
                MODE_NORMAL:
                begin
                    state_timer_next = sat_add16(state_timer_next, dt);
                    if (state_timer_next >= RETRY_CLEAR_MS)
                        retry_next = '0;
                    if (state_timer_next < BLANK_WINDOW)
                        stall_timer_next = '0;
                    else if (votes >= VOTES_NEEDED)
                        stall_timer_next = sat_add16(stall_timer_next, dt);
                    else
                        stall_timer_next = '0;

                    if ((state_timer_next >= BLANK_WINDOW)
                        && (stall_timer_next >= CONFIRM_WINDOW))
                    begin
                        state_timer_next = '0;
                        stall_timer_next = '0;
                        if ((near_hi || near_lo) && outward)
                        begin
                            mode_next = MODE_BACKOFF;
                            if (retry_next < RETRY_MAX)
                                retry_next = retry_next + 8'd1;
                            btgt_next = bt_clamped;
                            req       = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_FAULT;
                        end
                    end
                end
                MODE_BACKOFF:
                begin
                    state_timer_next = sat_add16(state_timer_next, dt);
                    if (state_timer_next >= BACKOFF_WINDOW)
                    begin
                        mode_next        = (retry_next > MAX_RETRIES) ? MODE_FAULT : MODE_COOLDOWN;
                        state_timer_next = '0;
                        stall_timer_next = '0;
                    end
                end
                MODE_COOLDOWN:
                begin
                    state_timer_next = sat_add16(state_timer_next, dt);
                    if (state_timer_next >= COOLDOWN_WINDOW)
                    begin
                        mode_next        = MODE_NORMAL;
                        state_timer_next = '0;
                        stall_timer_next = '0;
                    end
                end
                default:
                begin
                    // fault holds; its timers stay frozen
                end
            endcase
        end
    end

    // Result word
    always_comb
    begin
        result.out_cmd       = item.raw_cmd;
        result.out_target    = item.target_angle;
        result.protect_state = mode_next;
        result.fault         = (mode_next == MODE_FAULT);
        result.loop_reset    = req;
        result.reset_target  = req ? btgt_next : 16'sd0;
        if (item.active)
        begin
            case (mode_next)
                MODE_BACKOFF:
                begin
                    result.out_target = btgt_next;
                    if (cfg.backoff_limit == 15'd0)
                        result.out_cmd = 16'sd0;
                    else if (item.raw_cmd > $signed({1'b0, cfg.backoff_limit}))
                        result.out_cmd = $signed({1'b0, cfg.backoff_limit});
                    else if (item.raw_cmd < -$signed({1'b0, cfg.backoff_limit}))
                        result.out_cmd = -$signed({1'b0, cfg.backoff_limit});
                end
                MODE_COOLDOWN, MODE_FAULT:
                    result.out_cmd = 16'sd0;
                default:
                    result.out_cmd = item.raw_cmd;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NORMAL;
            state_timer_reg <= '0;
            stall_timer_reg <= '0;
            retry_reg       <= '0;
            btgt_reg        <= '0;
            active_prev_reg <= 1'b1;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            state_timer_reg <= state_timer_next;
            stall_timer_reg <= stall_timer_next;
            retry_reg       <= retry_next;
            btgt_reg        <= btgt_next;
            active_prev_reg <= active_prev_next;
        end
    end

endmodule
